// ----- design/motor_rpm_to_pwm_interpolator_unit_assert.svh -----
// assertion macros shared by the interpolator modules
// expects clk and arst_n in the scope of each use
`ifndef MOTOR_RPM_TO_PWM_INTERPOLATOR_UNIT_ASSERT_SVH
`define MOTOR_RPM_TO_PWM_INTERPOLATOR_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// property that must hold at every edge out of reset
`define MRPI_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("mrpi assertion failed");
// condition that must hold in the cycle after a trigger
`define MRPI_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("mrpi assertion failed");
`else
`define MRPI_ASSERT(lbl, prop)
`define MRPI_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ----- design/mrpi_pkg.sv -----
// shared types, calibration roms and slope tables of the rpm to pwm interpolator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mrpi_pkg;

	localparam int ROM_DEPTH   = 13;
	localparam int IDX_W       = 4;
	localparam int DIV_BITS    = 18;
	localparam int SLOPE_SCALE = 262144;
	localparam logic [16:0] DUTY_MAX = 17'd102399;

	// configuration register indexes
	localparam logic [1:0] CFG_MOTOR_SIDE = 2'd0;
	localparam logic [1:0] CFG_MIN_RPM    = 2'd1;
	localparam logic [1:0] CFG_MAX_RPM    = 2'd2;

	// guess status codes
	localparam logic [1:0] GS_OK          = 2'd0;
	localparam logic [1:0] GS_BELOW       = 2'd1;
	localparam logic [1:0] GS_NO_INTERVAL = 2'd2;

	// calibration points
	localparam logic [13:0] SPD_ROM [ROM_DEPTH] = '{
		14'd2000, 14'd2500, 14'd3000, 14'd3500, 14'd4000, 14'd4500, 14'd5000,
		14'd5500, 14'd6000, 14'd6500, 14'd7000, 14'd7500, 14'd8000};
	localparam logic [16:0] LDUTY_ROM [ROM_DEPTH] = '{
		17'd42394, 17'd44749, 17'd49050, 17'd52398, 17'd56678, 17'd64102, 17'd82176,
		17'd86272, 17'd89856, 17'd92621, 17'd95386, 17'd102308, 17'd102399};
	localparam logic [16:0] RDUTY_ROM [ROM_DEPTH] = '{
		17'd39834, 17'd44134, 17'd48640, 17'd52275, 17'd55296, 17'd60365, 17'd80128,
		17'd85555, 17'd89344, 17'd92365, 17'd95232, 17'd100352, 17'd102399};

	// segment widths, used only to build the slope tables
	function automatic int spd_step(input int i);
		return int'(SPD_ROM[i + 1]) - int'(SPD_ROM[i]);
	endfunction

	function automatic int left_step(input int i);
		return int'(LDUTY_ROM[i + 1]) - int'(LDUTY_ROM[i]);
	endfunction

	function automatic int right_step(input int i);
		return int'(RDUTY_ROM[i + 1]) - int'(RDUTY_ROM[i]);
	endfunction

	// q16.8 rpm per percent of each segment, rounded half up
	localparam logic [23:0] LSLOPE_ROM [ROM_DEPTH-1] = '{
		24'((spd_step(0) * SLOPE_SCALE + left_step(0) / 2) / left_step(0)),
		24'((spd_step(1) * SLOPE_SCALE + left_step(1) / 2) / left_step(1)),
		24'((spd_step(2) * SLOPE_SCALE + left_step(2) / 2) / left_step(2)),
		24'((spd_step(3) * SLOPE_SCALE + left_step(3) / 2) / left_step(3)),
		24'((spd_step(4) * SLOPE_SCALE + left_step(4) / 2) / left_step(4)),
		24'((spd_step(5) * SLOPE_SCALE + left_step(5) / 2) / left_step(5)),
		24'((spd_step(6) * SLOPE_SCALE + left_step(6) / 2) / left_step(6)),
		24'((spd_step(7) * SLOPE_SCALE + left_step(7) / 2) / left_step(7)),
		24'((spd_step(8) * SLOPE_SCALE + left_step(8) / 2) / left_step(8)),
		24'((spd_step(9) * SLOPE_SCALE + left_step(9) / 2) / left_step(9)),
		24'((spd_step(10) * SLOPE_SCALE + left_step(10) / 2) / left_step(10)),
		24'((spd_step(11) * SLOPE_SCALE + left_step(11) / 2) / left_step(11))};
	localparam logic [23:0] RSLOPE_ROM [ROM_DEPTH-1] = '{
		24'((spd_step(0) * SLOPE_SCALE + right_step(0) / 2) / right_step(0)),
		24'((spd_step(1) * SLOPE_SCALE + right_step(1) / 2) / right_step(1)),
		24'((spd_step(2) * SLOPE_SCALE + right_step(2) / 2) / right_step(2)),
		24'((spd_step(3) * SLOPE_SCALE + right_step(3) / 2) / right_step(3)),
		24'((spd_step(4) * SLOPE_SCALE + right_step(4) / 2) / right_step(4)),
		24'((spd_step(5) * SLOPE_SCALE + right_step(5) / 2) / right_step(5)),
		24'((spd_step(6) * SLOPE_SCALE + right_step(6) / 2) / right_step(6)),
		24'((spd_step(7) * SLOPE_SCALE + right_step(7) / 2) / right_step(7)),
		24'((spd_step(8) * SLOPE_SCALE + right_step(8) / 2) / right_step(8)),
		24'((spd_step(9) * SLOPE_SCALE + right_step(9) / 2) / right_step(9)),
		24'((spd_step(10) * SLOPE_SCALE + right_step(10) / 2) / right_step(10)),
		24'((spd_step(11) * SLOPE_SCALE + right_step(11) / 2) / right_step(11))};

	// side-selected duty point
	function automatic logic [16:0] duty_pt(input logic side, input logic [IDX_W-1:0] idx);
		return side ? RDUTY_ROM[idx] : LDUTY_ROM[idx];
	endfunction

	// side-selected segment slope
	function automatic logic [23:0] slope_pt(input logic side, input logic [IDX_W-1:0] idx);
		return side ? RSLOPE_ROM[idx] : LSLOPE_ROM[idx];
	endfunction

	typedef struct packed {
		logic [13:0] target_rpm;
		logic [16:0] query_duty;
	} mrpi_in_t;

	typedef struct packed {
		logic [16:0] duty_guess;
		logic [1:0]  guess_status;
		logic [23:0] slope_at_speed;
		logic        speed_segment_found;
		logic [23:0] slope_at_duty;
		logic        duty_segment_found;
	} mrpi_out_t;

	typedef struct packed {
		logic        motor_side;
		logic [13:0] min_target_rpm;
		logic [13:0] max_target_rpm;
	} mrpi_cfg_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic mult;
		logic div_init;
		logic div_step;
		logic finish;
	} mrpi_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic div_last;
		logic slot_free;
	} mrpi_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MULT,
		ST_DIV_INIT,
		ST_DIV,
		ST_FINISH
	} mrpi_state_t;

endpackage

`default_nettype wire

// ----- design/mrpi_ctrl.sv -----
// sequencer of the interpolator: scan, multiply, divide, write result
// depends on mrpi_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "motor_rpm_to_pwm_interpolator_unit_assert.svh"

module mrpi_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mrpi_pkg::mrpi_stat_t stat,
	output mrpi_pkg::mrpi_cmd_t  cmd
);
	import mrpi_pkg::*;

	mrpi_state_t state_q;
	mrpi_state_t state_nx;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nx = ST_SCAN;
			end
			ST_SCAN: begin
				if (stat.scan_last) state_nx = ST_MULT;
			end
			ST_MULT: begin
				state_nx = ST_DIV_INIT;
			end
			ST_DIV_INIT: begin
				state_nx = ST_DIV;
			end
			ST_DIV: begin
				if (stat.div_last) state_nx = ST_FINISH;
			end
			ST_FINISH: begin
				if (stat.slot_free) state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// commands to the datapath
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			ST_MULT: begin
				cmd.mult = 1'b1;
			end
			ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_FINISH: begin
				cmd.finish = stat.slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// one item in flight at a time
	`MRPI_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)
	// a result is written only into a free output slot
	`MRPI_ASSERT(a_finish_slot, cmd.finish |-> stat.slot_free)
	// the last scan step hands over to the multiply
	`MRPI_ASSERT_NEXT(a_scan_done, (state_q == ST_SCAN) && stat.scan_last, state_q == ST_MULT)

endmodule

`default_nettype wire

// ----- design/mrpi_datapath.sv -----
// datapath of the interpolator: segment search, multiplier, restoring divider, result register
// depends on mrpi_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "motor_rpm_to_pwm_interpolator_unit_assert.svh"

module mrpi_datapath #(
	parameter int TABLE_POINTS = 13
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mrpi_pkg::mrpi_cmd_t  cmd,
	output mrpi_pkg::mrpi_stat_t stat,
	input  mrpi_pkg::mrpi_cfg_t  cfg,
	input  mrpi_pkg::mrpi_in_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output mrpi_pkg::mrpi_out_t  out_data
);
	import mrpi_pkg::*;

	localparam int N_PTS = (TABLE_POINTS < ROM_DEPTH) ? TABLE_POINTS : ROM_DEPTH;
	localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(N_PTS - 2);
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(N_PTS - 1);
	localparam int CNT_W = $clog2(DIV_BITS);

	// item registers
	logic [13:0] rpm_q;
	logic [16:0] qduty_q;
	logic [13:0] x_q;
	logic        side_q;
	logic        below_q;
	logic        range_bad_q;
	logic        at_last_q;

	// search registers
	logic [IDX_W-1:0] scan_q;
	logic             hit_x_q, hit_r_q, hit_d_q;
	logic [IDX_W-1:0] idx_x_q, idx_r_q, idx_d_q;

	// arithmetic registers
	logic signed [32:0] prod_q;
	logic [31:0]        rem_q;
	logic [31:0]        dsh_q;
	logic [DIV_BITS-1:0] quo_q;
	logic               neg_q;
	logic [CNT_W-1:0]   bit_q;

	// result register
	mrpi_out_t out_q;
	logic      out_valid_q;

	// clamped speed at load
	logic [13:0] x_ld;
	assign x_ld = (in_data.target_rpm >= cfg.max_target_rpm) ? cfg.max_target_rpm
		: in_data.target_rpm;

	// one segment of each search per scan step
	logic [IDX_W-1:0] scan_nx;
	logic             seg_x, seg_r, seg_d;
	logic [16:0]      dlo, dhi;
	assign scan_nx = scan_q + 1'b1;
	assign dlo     = duty_pt(side_q, scan_q);
	assign dhi     = duty_pt(side_q, scan_nx);
	assign seg_x   = (SPD_ROM[scan_q] <= x_q) && (x_q < SPD_ROM[scan_nx]);
	assign seg_r   = (SPD_ROM[scan_q] <= rpm_q) && (rpm_q < SPD_ROM[scan_nx]);
	assign seg_d   = (dlo <= qduty_q) && (qduty_q < dhi);

	// duty step times speed offset in the segment of the clamped speed
	logic [IDX_W-1:0]   idx_x_nx;
	logic signed [17:0] dy;
	logic signed [14:0] dx;
	logic signed [32:0] prod;
	logic [13:0]        den;
	logic [32:0]        mag;
	assign idx_x_nx = idx_x_q + 1'b1;
	assign dy   = signed'({1'b0, duty_pt(side_q, idx_x_nx)}) - signed'({1'b0, duty_pt(side_q, idx_x_q)});
	assign dx   = signed'({1'b0, x_q - SPD_ROM[idx_x_q]});
	assign prod = dy * dx;
	assign den  = SPD_ROM[idx_x_nx] - SPD_ROM[idx_x_q];
	assign mag  = prod_q[32] ? 33'(-prod_q) : 33'(prod_q);

	// divider step
	logic rem_ge;
	assign rem_ge = rem_q >= dsh_q;

	// interpolated duty with saturation
	logic signed [19:0] yv;
	logic signed [19:0] qs;
	logic [16:0]        ysat;
	always_comb begin
		qs = signed'({2'b00, quo_q});
		yv = signed'({3'b000, duty_pt(side_q, idx_x_q)}) + (neg_q ? -qs : qs);
		if (yv < 0) begin
			ysat = '0;
		end else if (yv > signed'({3'b000, DUTY_MAX})) begin
			ysat = DUTY_MAX;
		end else begin
			ysat = yv[16:0];
		end
	end

	// result assembly
	mrpi_out_t res;
	always_comb begin
		res = '0;
		if (below_q) begin
			res.guess_status = GS_BELOW;
		end else if (range_bad_q) begin
			res.guess_status = GS_NO_INTERVAL;
		end else if (at_last_q) begin
			res.duty_guess   = duty_pt(side_q, LAST_IDX);
			res.guess_status = GS_OK;
		end else if (!hit_x_q) begin
			res.guess_status = GS_NO_INTERVAL;
		end else begin
			res.duty_guess   = ysat;
			res.guess_status = GS_OK;
		end
		res.speed_segment_found = hit_r_q;
		res.slope_at_speed      = hit_r_q ? slope_pt(side_q, idx_r_q) : '0;
		res.duty_segment_found  = hit_d_q;
		res.slope_at_duty       = hit_d_q ? slope_pt(side_q, idx_d_q) : '0;
	end

	// item capture, search and arithmetic
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rpm_q       <= in_data.target_rpm;
			qduty_q     <= in_data.query_duty;
			side_q      <= cfg.motor_side;
			x_q         <= x_ld;
			below_q     <= in_data.target_rpm < cfg.min_target_rpm;
			range_bad_q <= (x_ld < SPD_ROM[0]) || (x_ld > SPD_ROM[LAST_IDX]);
			at_last_q   <= x_ld == SPD_ROM[LAST_IDX];
			hit_x_q     <= 1'b0;
			hit_r_q     <= 1'b0;
			hit_d_q     <= 1'b0;
			idx_x_q     <= '0;
			idx_r_q     <= '0;
			idx_d_q     <= '0;
		end
		if (cmd.scan) begin
			if (seg_x) begin
				hit_x_q <= 1'b1;
				idx_x_q <= scan_q;
			end
			if (seg_r) begin
				hit_r_q <= 1'b1;
				idx_r_q <= scan_q;
			end
			if (seg_d) begin
				hit_d_q <= 1'b1;
				idx_d_q <= scan_q;
			end
		end
		if (cmd.mult) begin
			prod_q <= prod;
		end
		if (cmd.div_init) begin
			neg_q <= prod_q[32];
			rem_q <= mag[31:0] + 32'(den >> 1);
			dsh_q <= 32'(den) << (DIV_BITS - 1);
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			if (rem_ge) rem_q <= rem_q - dsh_q;
			quo_q <= {quo_q[DIV_BITS-2:0], rem_ge};
			dsh_q <= dsh_q >> 1;
		end
		if (cmd.finish) begin
			out_q <= res;
		end
	end

	// scan and divide counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			bit_q  <= '0;
		end else begin
			if (cmd.load) begin
				scan_q <= '0;
			end else if (cmd.scan) begin
				scan_q <= scan_nx;
			end
			if (cmd.div_init) begin
				bit_q <= CNT_W'(DIV_BITS - 1);
			end else if (cmd.div_step) begin
				bit_q <= bit_q - 1'b1;
			end
		end
	end

	// output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.scan_last = scan_q == SCAN_LAST;
	assign stat.div_last  = bit_q == '0;
	assign stat.slot_free = !out_valid_q || out_ready;
	assign out_valid      = out_valid_q;
	assign out_data       = out_q;

	// saturated duty stays in range
	`MRPI_ASSERT(a_duty_range, out_valid_q |-> (out_q.duty_guess <= DUTY_MAX))
	// error statuses carry zero duty
	`MRPI_ASSERT(a_err_zero, (out_valid_q && (out_q.guess_status != GS_OK)) |-> (out_q.duty_guess == '0))
	// a written result is offered next cycle
	`MRPI_ASSERT_NEXT(a_finish_valid, cmd.finish, out_valid_q)

endmodule

`default_nettype wire

// ----- design/motor_rpm_to_pwm_interpolator_unit.sv -----
// Takes a target speed and a query duty per beat and returns one result beat: the duty
// interpolated from the calibration table of the selected motor side, a status, and the
// q16.8 rpm-per-percent slopes of the segments holding the speed and the query duty.
// One item is worked at a time, through the segment scan (one table segment per cycle)
// and the 18-step restoring divider for the rounding division of the interpolation;
// slopes come from constant tables. The next item is taken while a finished result
// still waits in the output register; a result that is not taken holds the item after
// it in its finish step. Configuration is written through cfg_we/cfg_addr/cfg_wdata;
// the user must write it only while the block is idle, which the block does not enforce.
// depends on mrpi_pkg, mrpi_ctrl, mrpi_datapath
`timescale 1ns / 1ps
`default_nettype none

module motor_rpm_to_pwm_interpolator_unit #(
	parameter int TABLE_POINTS = 13
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mrpi_pkg::mrpi_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output mrpi_pkg::mrpi_out_t out_data,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_addr,
	input  logic [13:0]         cfg_wdata
);
	import mrpi_pkg::*;

	mrpi_cfg_t  cfg_q;
	mrpi_cmd_t  cmd;
	mrpi_stat_t stat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.motor_side     <= 1'b0;
			cfg_q.min_target_rpm <= 14'd2000;
			cfg_q.max_target_rpm <= 14'd7500;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_MOTOR_SIDE: cfg_q.motor_side     <= cfg_wdata[0];
				CFG_MIN_RPM:    cfg_q.min_target_rpm <= cfg_wdata;
				CFG_MAX_RPM:    cfg_q.max_target_rpm <= cfg_wdata;
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	mrpi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mrpi_datapath #(
		.TABLE_POINTS (TABLE_POINTS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg       (cfg_q),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
